FILE: rtl/aesbe_pkg.sv
`default_nettype none
package aesbe_pkg;

  localparam int NumCells = 14;

  // key length codes
  localparam logic [1:0] KLEN_128 = 2'd0;
  localparam logic [1:0] KLEN_192 = 2'd1;
  localparam logic [1:0] KLEN_256 = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_LENGTH = 3'd0;
  localparam logic [2:0] REG_KEY_WORD0  = 3'd1;
  localparam logic [2:0] REG_KEY_WORD1  = 3'd2;
  localparam logic [2:0] REG_KEY_WORD2  = 3'd3;
  localparam logic [2:0] REG_KEY_WORD3  = 3'd4;

  typedef struct packed {
    logic [63:0] plain_high;
    logic [63:0] plain_low;
  } plain_t;

  typedef struct packed {
    logic [63:0] cipher_high;
    logic [63:0] cipher_low;
  } cipher_t;

  // what travels from one round cell to the next
  typedef struct packed {
    logic [1:0]          klen;
    logic [7:0]          rcon;
    logic [127:0]        state;
    logic [7:0][31:0]    hist;   // last eight schedule words, [7] newest
    logic [7:0][31:0]    key;    // raw key words, [0] first
  } stage_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xt(input logic [7:0] x);
    xt = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

FILE: rtl/aesbe_round_cell.sv
`default_nettype none
module aesbe_round_cell
  import aesbe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  logic [3:0] round_num,
  input  logic       prev_valid,
  input  stage_t     prev,
  output logic       cur_valid,
  output stage_t     cur
);

  stage_t cur_next;

  // schedule words 4r..4r+3, then one cipher round
  always_comb begin
    logic [3:0]       nk;
    logic [3:0]       nr;
    logic [7:0][31:0] h;
    logic [7:0]       rc;
    logic [5:0]       idx;
    logic [2:0]       m;
    logic [11:0]      q;
    logic [31:0]      t;
    logic [31:0]      w;
    logic [127:0]     rk;
    logic [7:0]       s [16];
    logic [7:0]       u [16];
    logic [7:0]       a0, a1, a2, a3, al;
    logic [127:0]     ns;

    nk = (prev.klen == KLEN_128) ? 4'd4 : (prev.klen == KLEN_192) ? 4'd6 : 4'd8;
    nr = nk + 4'd6;
    h  = prev.hist;
    rc = prev.rcon;
    rk = '0;
    for (int k = 0; k < 4; k++) begin
      idx = {round_num, 2'(k)};
      q   = 12'(idx) * 12'd43;
      if (nk == 4'd4)      m = {1'b0, idx[1:0]};
      else if (nk == 4'd8) m = idx[2:0];
      else begin
        m = 3'(idx - 6'(q[11:8]) * 6'd6);
      end
      t = h[7];
      if (idx < {2'b00, nk}) begin
        w = prev.key[idx[2:0]];
      end else begin
        if (m == 3'd0) begin
          t  = sub_word({t[23:0], t[31:24]}) ^ {rc, 24'h0};
          rc = xt(rc);
        end else if (nk == 4'd8 && m == 3'd4) begin
          t = sub_word(t);
        end
        w = h[3'(4'd8 - nk)] ^ t;
      end
      h  = {w, h[7:1]};
      rk = {rk[95:0], w};
    end

    // SubBytes and ShiftRows
    for (int i = 0; i < 16; i++) s[i] = prev.state[127 - 8*i -: 8];
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        u[c*4 + r] = SBOX[s[((c + r) & 3)*4 + r]];

    // MixColumns, left out in the last round
    a0 = '0; a1 = '0; a2 = '0; a3 = '0; al = '0;
    if ({2'b00, round_num} != {2'b00, nr}) begin
      for (int c = 0; c < 4; c++) begin
        a0 = u[c*4]; a1 = u[c*4+1]; a2 = u[c*4+2]; a3 = u[c*4+3];
        al = a0 ^ a1 ^ a2 ^ a3;
        u[c*4]   = a0 ^ al ^ xt(a0 ^ a1);
        u[c*4+1] = a1 ^ al ^ xt(a1 ^ a2);
        u[c*4+2] = a2 ^ al ^ xt(a2 ^ a3);
        u[c*4+3] = a3 ^ al ^ xt(a3 ^ a0);
      end
    end
    for (int i = 0; i < 16; i++) ns[127 - 8*i -: 8] = u[i];

    cur_next       = prev;
    cur_next.hist  = h;
    cur_next.rcon  = rc;
    // rounds past the key's count pass the block through
    if ({2'b00, round_num} <= {2'b00, nr}) cur_next.state = ns ^ rk;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
    end else if (advance) begin
      cur_valid <= prev_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cur <= cur_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/aes_block_encrypt.sv
`default_nettype none
// AES block encryptor, 128/192/256-bit keys. One block can be taken every
// clock while in_stall is low; each block passes an entry register and
// fourteen round cells before its ciphertext appears (shorter keys simply
// pass through the spare cells). The round keys are worked out inside the
// cells alongside the data, so a key written while the pipeline is empty is
// used by the very next block. A stall with a ciphertext waiting freezes the whole chain.
module aes_block_encrypt
  import aesbe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  plain_t      in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output cipher_t     out_data
);

  logic [1:0]  key_length;
  logic [63:0] key_word0, key_word1, key_word2, key_word3;
  logic        advance;
  logic        v [NumCells + 1];
  stage_t      st [NumCells + 1];
  stage_t      entry_next;

  // key registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= '0;
      key_word0  <= '0;
      key_word1  <= '0;
      key_word2  <= '0;
      key_word3  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_KEY_LENGTH: key_length <= cfg_data[1:0];
        REG_KEY_WORD0:  key_word0  <= cfg_data;
        REG_KEY_WORD1:  key_word1  <= cfg_data;
        REG_KEY_WORD2:  key_word2  <= cfg_data;
        REG_KEY_WORD3:  key_word3  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign advance  = !(v[NumCells] && out_stall);
  assign in_stall = !advance;

  // entry: initial AddRoundKey with schedule words 0..3
  always_comb begin
    entry_next.klen  = key_length;
    entry_next.rcon  = 8'h01;
    entry_next.key   = {key_word3[31:0], key_word3[63:32], key_word2[31:0], key_word2[63:32],
                        key_word1[31:0], key_word1[63:32], key_word0[31:0], key_word0[63:32]};
    entry_next.hist  = {key_word1[31:0], key_word1[63:32], key_word0[31:0], key_word0[63:32],
                        128'h0};
    entry_next.state = {in_data.plain_high, in_data.plain_low} ^ {key_word0, key_word1};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (advance) begin
      v[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0] <= entry_next;
    end
  end

  // chain of round cells
  for (genvar g = 0; g < NumCells; g++) begin : g_cell
    aesbe_round_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .advance    (advance),
      .round_num  (4'(g + 1)),
      .prev_valid (v[g]),
      .prev       (st[g]),
      .cur_valid  (v[g + 1]),
      .cur        (st[g + 1])
    );
  end

  assign out_valid            = v[NumCells];
  assign out_data.cipher_high = st[NumCells].state[127:64];
  assign out_data.cipher_low  = st[NumCells].state[63:0];

endmodule
`default_nettype wire
